FILE: rtl/core/hld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hld_pkg;

  localparam int MAX_WORDS = 2048;
  localparam int WCNT_W = $clog2(MAX_WORDS + 1);
  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] COUNT_CAP = 17'd65536;
  localparam logic [CNT_W-1:0] THRESH_RESET = 17'd6554;
  localparam int PC_W = 6;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    cnt_t s11;
    cnt_t s10;
    cnt_t s01;
    cnt_t s00;
  } sums_t;

  typedef struct packed {
    logic              degenerate;
    logic              passes;
    logic signed [17:0] d_prime;
    logic signed [15:0] d_value;
    cnt_t              r_squared;
    cnt_t              total_count;
    sums_t             counts;
  } result_t;

  function automatic logic [PC_W-1:0] popcount32(input logic [31:0] w);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + {{(PC_W-1){1'b0}}, w[i]};
    end
    return n;
  endfunction

  function automatic cnt_t sat_add(input cnt_t s, input logic [PC_W-1:0] v);
    logic [CNT_W:0] t;
    t = {1'b0, s} + {{(CNT_W+1-PC_W){1'b0}}, v};
    return (t > {1'b0, COUNT_CAP}) ? COUNT_CAP : t[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hld_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hld_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [127:0]  s_tdata,
  input  wire logic          s_tlast,
  input  wire logic          q_full,
  output logic               q_push,
  output hld_pkg::sums_t     q_data
);

  hld_pkg::sums_t sums, sums_next;
  logic [hld_pkg::WCNT_W-1:0] words_seen;
  logic accept, room;
  logic [31:0] fz, fo, sz, so;

  assign fz = s_tdata[31:0];
  assign fo = s_tdata[63:32];
  assign sz = s_tdata[95:64];
  assign so = s_tdata[127:96];

  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;
  assign room = words_seen < hld_pkg::WCNT_W'(hld_pkg::MAX_WORDS);

  always_comb begin
    sums_next = sums;
    if (room) begin
      sums_next.s00 = hld_pkg::sat_add(sums.s00, hld_pkg::popcount32(fz & sz));
      sums_next.s01 = hld_pkg::sat_add(sums.s01, hld_pkg::popcount32(fz & so));
      sums_next.s10 = hld_pkg::sat_add(sums.s10, hld_pkg::popcount32(fo & sz));
      sums_next.s11 = hld_pkg::sat_add(sums.s11, hld_pkg::popcount32(fo & so));
    end
  end

  assign q_push = accept && s_tlast;
  assign q_data = sums_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
      words_seen <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        sums <= '0;
        words_seen <= '0;
      end else begin
        sums <= sums_next;
        if (room) words_seen <= words_seen + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/hld_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module hld_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hld_pkg::sums_t push_data,
  input  wire logic           pop,
  output hld_pkg::sums_t      pop_data,
  output logic                full,
  output logic                empty
);

  hld_pkg::sums_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/hld_back.sv
`timescale 1ns / 1ps
`default_nettype none
module hld_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire hld_pkg::cnt_t   r2_threshold,
  input  wire logic            q_empty,
  input  wire hld_pkg::sums_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output hld_pkg::result_t     out_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_MAG  = 8'b0000_1000,
    S_DLD  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_DRND = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  localparam logic [3:0] OP_AD = 4'd0, OP_BC = 4'd1, OP_R12 = 4'd2, OP_C12 = 4'd3,
                         OP_R1C1 = 4'd4, OP_R2C2 = 4'd5, OP_R1C2 = 4'd6,
                         OP_R2C1 = 4'd7, OP_TT = 4'd8, OP_MSQ = 4'd9, OP_DEN = 4'd10;
  localparam logic [1:0] DIV_RSQ = 2'd0, DIV_DV = 2'd1, DIV_DP = 2'd2;

  state_t state;
  hld_pkg::sums_t cnt;
  logic [18:0] t;
  logic [17:0] r1, r2, c1, c2;
  logic degen, neg;
  logic [3:0] op;
  logic half;
  logic [53:0] acc;
  logic [35:0] p_ad, p_bc, p_r12, p_c12, p_11, p_22, p_12, p_21, mag, m;
  logic [37:0] p_tt;
  logic [65:0] p_msq;
  logic [71:0] p_den;
  logic [35:0] mx, my;
  logic [53:0] prod;
  logic [71:0] mres;
  logic [81:0] rem;
  logic [88:0] dsh;
  logic [71:0] dden;
  logic [17:0] q, qr, rsq_q, dv_q, dp_q;
  logic [4:0] qbit;
  logic [1:0] dop;
  logic [18:0] t_sum;
  logic ge;

  assign t_sum = {2'b0, cnt.s00} + {2'b0, cnt.s01} + {2'b0, cnt.s10} + {2'b0, cnt.s11};

  always_comb begin
    case (op)
      OP_AD:   begin mx = {19'b0, cnt.s00}; my = {19'b0, cnt.s11}; end
      OP_BC:   begin mx = {19'b0, cnt.s01}; my = {19'b0, cnt.s10}; end
      OP_R12:  begin mx = {18'b0, r1}; my = {18'b0, r2}; end
      OP_C12:  begin mx = {18'b0, c1}; my = {18'b0, c2}; end
      OP_R1C1: begin mx = {18'b0, r1}; my = {18'b0, c1}; end
      OP_R2C2: begin mx = {18'b0, r2}; my = {18'b0, c2}; end
      OP_R1C2: begin mx = {18'b0, r1}; my = {18'b0, c2}; end
      OP_R2C1: begin mx = {18'b0, r2}; my = {18'b0, c1}; end
      OP_TT:   begin mx = {17'b0, t}; my = {17'b0, t}; end
      OP_MSQ:  begin mx = mag; my = mag; end
      OP_DEN:  begin mx = p_r12; my = p_c12; end
      default: begin mx = '0; my = '0; end
    endcase
  end

  // one 36x18 product per cycle; a full product sums the partial products of the low and high halves of my
  assign prod = mx * (half ? my[35:18] : my[17:0]);
  assign mres = {18'b0, acc} + {prod, 18'b0};

  assign ge = {7'b0, rem} >= dsh;
  assign qr = q + {17'b0, ({rem, 1'b0} >= {11'b0, dden})};
  assign q_pop = (state == S_IDLE) && !q_empty;

  logic [16:0] rsq_c, dp_c;
  logic [14:0] dv_c;
  logic [18:0] t_c;
  always_comb begin
    rsq_c = (rsq_q > 18'd65536) ? 17'd65536 : rsq_q[16:0];
    dv_c = (dv_q > 18'd16384) ? 15'd16384 : dv_q[14:0];
    dp_c = (dp_q > 18'd65536) ? 17'd65536 : dp_q[16:0];
    t_c = (t > 19'd65536) ? 19'd65536 : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cnt <= q_data;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          t <= t_sum;
          r1 <= {1'b0, cnt.s00} + {1'b0, cnt.s01};
          r2 <= {1'b0, cnt.s10} + {1'b0, cnt.s11};
          c1 <= {1'b0, cnt.s00} + {1'b0, cnt.s10};
          c2 <= {1'b0, cnt.s01} + {1'b0, cnt.s11};
          degen <= (t_sum == '0) || (cnt.s00 == '0 && cnt.s01 == '0) ||
                   (cnt.s10 == '0 && cnt.s11 == '0) ||
                   (cnt.s00 == '0 && cnt.s10 == '0) ||
                   (cnt.s01 == '0 && cnt.s11 == '0);
          neg <= 1'b0;
          rsq_q <= '0;
          dv_q <= '0;
          dp_q <= '0;
          op <= OP_AD;
          half <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (degen) begin
            state <= S_FIN;
          end else if (!half) begin
            acc <= prod;
            half <= 1'b1;
          end else begin
            half <= 1'b0;
            case (op)
              OP_AD:   p_ad <= mres[35:0];
              OP_BC:   p_bc <= mres[35:0];
              OP_R12:  p_r12 <= mres[35:0];
              OP_C12:  p_c12 <= mres[35:0];
              OP_R1C1: p_11 <= mres[35:0];
              OP_R2C2: p_22 <= mres[35:0];
              OP_R1C2: p_12 <= mres[35:0];
              OP_R2C1: p_21 <= mres[35:0];
              OP_TT:   p_tt <= mres[37:0];
              OP_MSQ:  p_msq <= mres[65:0];
              default: p_den <= mres;
            endcase
            op <= op + 4'd1;
            if (op == OP_TT) state <= S_MAG;
            else if (op == OP_DEN) begin
              dop <= DIV_RSQ;
              state <= S_DLD;
            end
          end
        end
        S_MAG: begin
          neg <= p_ad < p_bc;
          mag <= (p_ad < p_bc) ? p_bc - p_ad : p_ad - p_bc;
          if (p_ad < p_bc) m <= (p_11 < p_22) ? p_11 : p_22;
          else m <= (p_12 < p_21) ? p_12 : p_21;
          state <= S_MUL;
        end
        S_DLD: begin
          case (dop)
            DIV_RSQ: begin
              rem <= {p_msq, 16'b0};
              dden <= p_den;
              dsh <= {p_den, 17'b0};
            end
            DIV_DV: begin
              rem <= {30'b0, mag, 16'b0};
              dden <= {34'b0, p_tt};
              dsh <= {34'b0, p_tt, 17'b0};
            end
            default: begin
              rem <= {30'b0, mag, 16'b0};
              dden <= {36'b0, m};
              dsh <= {36'b0, m, 17'b0};
            end
          endcase
          q <= '0;
          qbit <= 5'd17;
          state <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            rem <= rem - dsh[81:0];
            q[qbit] <= 1'b1;
          end
          dsh <= dsh >> 1;
          if (qbit == 5'd0) state <= S_DRND;
          else qbit <= qbit - 5'd1;
        end
        S_DRND: begin
          case (dop)
            DIV_RSQ: rsq_q <= qr;
            DIV_DV:  dv_q <= qr;
            default: dp_q <= qr;
          endcase
          if (dop == DIV_DP) state <= S_FIN;
          else begin
            dop <= dop + 2'd1;
            state <= S_DLD;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.counts <= cnt;
            out_data.total_count <= t_c[16:0];
            out_data.r_squared <= rsq_c;
            out_data.d_value <= neg ? -$signed({1'b0, dv_c}) : $signed({1'b0, dv_c});
            out_data.d_prime <= neg ? -$signed({1'b0, dp_c}) : $signed({1'b0, dp_c});
            out_data.passes <= !degen && (rsq_c >= r2_threshold);
            out_data.degenerate <= degen;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/haplotype_ld_r2.sv
`timescale 1ns / 1ps
`default_nettype none
// Linkage disequilibrium of two biallelic variants from haplotype bit masks.
// Mask words are taken one per cycle while the queue is not full, and
// popcounts of the four allele pairs accumulate per pair; the word with tlast
// closes the pair and hands its four counts to a two-entry queue. A sequencer
// then computes r2, D and D prime with one shared 36x18 multiplier (eleven
// products) and one restoring divider (three quotients). The front keeps
// streaming words while the back works and stalls only when the queue is
// full. Degenerate pairs (a zero total or marginal) skip the products and
// divisions and finish with zero ratios. A threshold write applies to later
// results.
module haplotype_ld_r2 (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // first_zero_word, first_one_word, second_zero_word, second_one_word
  input  wire logic [127:0] s_tdata,
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // count_zero_zero, count_zero_one, count_one_zero, count_one_one,
  // total_count, r_squared, d_value, d_prime
  output logic [135:0]      m_tdata,
  // passes, degenerate
  output logic [1:0]        m_tuser,
  input  wire logic         cfg_wr_en,
  input  wire logic [16:0]  cfg_wr_data
);

  hld_pkg::cnt_t r2_threshold;
  hld_pkg::sums_t push_data, pop_data;
  hld_pkg::result_t res;
  logic q_full, q_empty, q_push, q_pop;

  always_ff @(posedge clk) begin
    if (rst) r2_threshold <= hld_pkg::THRESH_RESET;
    else if (cfg_wr_en) r2_threshold <= cfg_wr_data;
  end

  hld_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tlast(s_tlast), .q_full(q_full),
    .q_push(q_push), .q_data(push_data)
  );

  hld_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(push_data),
    .pop(q_pop), .pop_data(pop_data), .full(q_full), .empty(q_empty)
  );

  hld_back u_back (
    .clk(clk), .rst(rst), .r2_threshold(r2_threshold), .q_empty(q_empty),
    .q_data(pop_data), .q_pop(q_pop), .out_valid(m_tvalid),
    .out_ready(m_tready), .out_data(res)
  );

  assign m_tdata = {res.d_prime, res.d_value, res.r_squared, res.total_count,
                    res.counts.s11, res.counts.s10, res.counts.s01, res.counts.s00};
  assign m_tuser = {res.degenerate, res.passes};

  a_pass_not_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("passing pair flagged degenerate");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[135:85] == '0)
    else $error("degenerate pair with nonzero ratios");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[84:68] >= m_tdata[16:0] && m_tdata[84:68] >= m_tdata[67:51])
    else $error("total below a haplotype count");

endmodule
`default_nettype wire
